### hw/rtl/assert_macros.svh
// assertion helpers for the median filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/smf_pkg.sv
package smf_pkg;

  // width of the window size register
  localparam int unsigned CFG_BITS = 5;

  // window size after reset
  localparam logic [CFG_BITS-1:0] WIN_RESET = 5'd3;

  // control shared by every cell of the chain
  typedef struct packed {
    logic shift;   // take a new item into the tap chain and load the sort row
    logic sort;    // one odd-even compare-exchange round
    logic phase;   // 0: pairs start at even cells, 1: at odd cells
  } cell_ctrl_t;

endpackage

### hw/rtl/smf_cell.sv
module smf_cell #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  smf_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          in_win_i,
  input  logic signed [SAMPLE_BITS-1:0] w_left_i,
  input  logic signed [SAMPLE_BITS-1:0] s_left_i,
  input  logic signed [SAMPLE_BITS-1:0] s_right_i,
  output logic signed [SAMPLE_BITS-1:0] w_o,
  output logic signed [SAMPLE_BITS-1:0] s_o
);

  localparam logic ODD = ((INDEX % 2) == 1);
  localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic signed [SAMPLE_BITS-1:0] w_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [SAMPLE_BITS-1:0] s_d;
  logic                          lower;

  // lower cell of its pair keeps the min, upper keeps the max
  assign lower = (ctrl_i.phase == ODD);

  always_comb begin
    s_d = s_q;
    if (ctrl_i.shift) begin
      // cells outside the window sort to the top and never move
      s_d = in_win_i ? w_left_i : MAXV;
    end else if (ctrl_i.sort) begin
      if (lower) begin
        s_d = (s_q > s_right_i) ? s_right_i : s_q;
      end else begin
        s_d = (s_left_i > s_q) ? s_left_i : s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      w_q <= w_left_i;
    end
    s_q <= s_d;
  end

  assign w_o = w_q;
  assign s_o = s_q;

endmodule

### hw/rtl/sliding_median_filter.sv
// Sliding-window median filter. Samples enter one item at a time into a row of
// MAX_WINDOW cells that hold the most recent samples, newest in cell 0. Each
// item that completes a window and is not marked end_of_signal gives one
// result: the middle value of the window (odd size) or the floored mean of the
// two middle values (even size). The item marked end_of_signal gives no median;
// instead the last window_size samples held (fewer if the signal was shorter)
// come out unchanged, oldest first, with is_raw set and is_last on the newest.
// The next item starts a new signal. Window size 0 acts as 1, sizes above
// MAX_WINDOW act as MAX_WINDOW; write it only while the block is idle.
// Steps: an item that gives no result leaves the block ready for the next item;
// a median item is followed by W rounds (W = effective window size) of odd-even
// transposition sort that run across the cell row, then the median goes to the
// output register; the last item gives its N pass-through results one per cycle
// through the output register while the output is not stalled. The output register
// lets the next item in while a result still waits to be taken.
`include "assert_macros.svh"

module sliding_median_filter #(
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // window size register
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [smf_pkg::CFG_BITS-1:0]     cfg_data_i,
  // sample items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic                             end_of_signal_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]    value_o,
  output logic                             is_raw_o,
  output logic                             is_last_o
);

  localparam int unsigned WB = $clog2(MAX_WINDOW + 1);  // counts 0..MAX_WINDOW
  localparam int unsigned IW = $clog2(MAX_WINDOW);      // cell index
  localparam logic [WB-1:0] MAXW = WB'(MAX_WINDOW);
  localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_MEDIAN,
    ST_TAIL
  } state_e;

  state_e                        state_q;
  logic [smf_pkg::CFG_BITS-1:0]  win_q;
  logic [WB-1:0]                 seen_q;
  logic [WB-1:0]                 round_q;
  logic [WB-1:0]                 cnt_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] value_q;
  logic                          is_raw_q;
  logic                          is_last_q;

  logic [WB-1:0]                 eff_win;
  logic [WB-1:0]                 seen_next;
  logic [WB-1:0]                 avail;
  logic                          in_accept;
  logic                          slot_free;
  smf_pkg::cell_ctrl_t           ctrl;

  logic signed [SAMPLE_BITS-1:0] w_all [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] s_all [MAX_WINDOW];

  // median pick
  logic [WB-1:0]                 mid;
  logic [WB-1:0]                 mid_m1;
  logic signed [SAMPLE_BITS-1:0] med_hi;
  logic signed [SAMPLE_BITS-1:0] med_lo;
  logic signed [SAMPLE_BITS:0]   med_sum;
  logic signed [SAMPLE_BITS-1:0] median;

  // tail pick
  logic [WB-1:0]                 cnt_m1;
  logic signed [SAMPLE_BITS-1:0] tail_val;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // clamp the window size to 1..MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      eff_win = WB'(1);
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      eff_win = MAXW;
    end else begin
      eff_win = WB'(win_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign seen_next = (seen_q < MAXW) ? seen_q + WB'(1) : seen_q;
  assign avail     = (seen_next < eff_win) ? seen_next : eff_win;

  assign ctrl.shift = in_accept;
  assign ctrl.sort  = (state_q == ST_SORT);
  assign ctrl.phase = round_q[0];

  // the cell row: tap chain plus sort row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                          in_win;
    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] s_left;
    logic signed [SAMPLE_BITS-1:0] s_right;

    assign in_win = (32'(i) < 32'(eff_win));

    if (i == 0) begin : g_first
      assign w_left = sample_i;
      assign s_left = MINV;
    end else begin : g_inner_l
      assign w_left = w_all[i-1];
      assign s_left = s_all[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign s_right = MAXV;
    end else begin : g_inner_r
      assign s_right = s_all[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .in_win_i  (in_win),
      .w_left_i  (w_left),
      .s_left_i  (s_left),
      .s_right_i (s_right),
      .w_o       (w_all[i]),
      .s_o       (s_all[i])
    );
  end

  // middle of the sorted window; even sizes take the floored mean
  assign mid     = eff_win >> 1;
  assign mid_m1  = mid - WB'(1);
  assign med_hi  = s_all[mid[IW-1:0]];
  assign med_lo  = s_all[mid_m1[IW-1:0]];
  assign med_sum = {med_lo[SAMPLE_BITS-1], med_lo} + {med_hi[SAMPLE_BITS-1], med_hi};
  assign median  = eff_win[0] ? med_hi : med_sum[SAMPLE_BITS:1];

  // tail reads oldest first
  assign cnt_m1   = cnt_q - WB'(1);
  assign tail_val = w_all[cnt_m1[IW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= smf_pkg::WIN_RESET;
      seen_q      <= '0;
      round_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      is_raw_q    <= 1'b0;
      is_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end

      // result taken downstream
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (end_of_signal_i) begin
              // pass the held tail through, then start a new signal
              cnt_q   <= avail;
              seen_q  <= '0;
              state_q <= ST_TAIL;
            end else begin
              seen_q <= seen_next;
              if (avail == eff_win) begin
                round_q <= '0;
                state_q <= ST_SORT;
              end
            end
          end
        end
        ST_SORT: begin
          // W rounds sort W values
          round_q <= round_q + WB'(1);
          if (round_q == eff_win - WB'(1)) begin
            state_q <= ST_MEDIAN;
          end
        end
        ST_MEDIAN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            value_q     <= median;
            is_raw_q    <= 1'b0;
            is_last_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        ST_TAIL: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            value_q     <= tail_val;
            is_raw_q    <= 1'b1;
            is_last_q   <= (cnt_q == WB'(1));
            cnt_q       <= cnt_m1;
            if (cnt_q == WB'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign is_raw_o    = is_raw_q;
  assign is_last_o   = is_last_q;

  // a tail pass always has a sample left to send
  `ASSERT_CLK(a_tail_cnt, (state_q == ST_TAIL) |-> (cnt_q != '0), "tail count ran out")
  // sample count saturates at the row length
  `ASSERT_CLK(a_seen_max, seen_q <= MAXW, "sample count beyond row length")
  // the sort row is ordered at its low end once the rounds are done
  `ASSERT_CLK(a_sorted, (state_q == ST_MEDIAN) |-> (s_all[0] <= s_all[1]), "sort row out of order")
  // only pass-through results close a signal
  `ASSERT_CLK(a_last_raw, (out_valid_o && is_last_o) |-> is_raw_o, "median marked last")

endmodule

### dv/sliding_median_filter_test.sv
`timescale 1ns / 100ps

module sliding_median_filter_test;

  localparam int unsigned MAX_WINDOW  = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CFG_BITS    = smf_pkg::CFG_BITS;

  // idle time before a window size write, longer than a median item takes at the full window size
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_WINDOW + 8;
  // run limit, far above the slowest correct run with the worst stalls
  localparam int unsigned CYCLE_LIMIT   = 500000;

  // one result item as the block gives it
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          is_raw;
    logic                          is_last;
  } result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_BITS-1:0]           cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i        = '0;
  logic                          end_of_signal_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic signed [SAMPLE_BITS-1:0] value_o;
  logic                          is_raw_o;
  logic                          is_last_o;

  sliding_median_filter #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_signal_i(end_of_signal_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .is_raw_o       (is_raw_o),
    .is_last_o      (is_last_o)
  );

  // predictor state: own copy of the sample row, the fill count and the window size
  logic signed [SAMPLE_BITS-1:0] held_samples [MAX_WINDOW];
  int unsigned                   held_count = 0;
  logic [CFG_BITS-1:0]           window_cfg = smf_pkg::WIN_RESET;

  // results still owed by the block, oldest first
  result_t     pending_results [$];
  result_t     oldest_result;
  int unsigned items_sent  = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  // chance in percent that the sender idles or the receiver stalls in a cycle
  int unsigned in_idle_pct   = 14;
  int unsigned out_stall_pct = 74;

  // window size zero acts as one, sizes above the row length saturate
  function automatic int unsigned active_window();
    if (window_cfg == 0) return 1;
    if (window_cfg > MAX_WINDOW) return MAX_WINDOW;
    return 32'(window_cfg);
  endfunction

  // median of the newest len samples held
  function automatic logic signed [SAMPLE_BITS-1:0] window_median(input int unsigned len);
    logic signed [SAMPLE_BITS-1:0] sorted [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] key;
    logic signed [SAMPLE_BITS:0]   pair_sum;
    int                            i;
    int                            j;
    for (i = 0; i < len; i++) sorted[i] = held_samples[i];
    // insertion sort, ascending
    for (i = 1; i < len; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (len % 2) return sorted[len/2];
    // full width sum, dropping the low bit floors toward minus infinity
    pair_sum = sorted[len/2 - 1] + sorted[len/2];
    return pair_sum[SAMPLE_BITS:1];
  endfunction

  // advance the predictor by one accepted item and queue what it causes
  task automatic predict_sample(input logic signed [SAMPLE_BITS-1:0] sample, input logic eos);
    int unsigned win;
    int unsigned avail;
    int unsigned k;
    win = active_window();
    for (k = MAX_WINDOW - 1; k > 0; k--) held_samples[k] = held_samples[k-1];
    held_samples[0] = sample;
    if (held_count < MAX_WINDOW) held_count++;
    avail = (held_count < win) ? held_count : win;
    if (eos) begin
      // tail passes through oldest first, is_last on the newest
      for (k = avail; k > 0; k--) begin
        pending_results.push_back('{value: held_samples[k-1], is_raw: 1'b1,
                                    is_last: (k == 1)});
      end
      held_count = 0;
    end else if (avail == win) begin
      pending_results.push_back('{value: window_median(win), is_raw: 1'b0, is_last: 1'b0});
    end
  endtask

  // receiver: stalls at random, rate set per phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // every accepted result against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual value %0d",
                 $time, value_o);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("value", oldest_result.value, value_o);
        check_field("is_raw", oldest_result.is_raw, is_raw_o);
        check_field("is_last", oldest_result.is_last, is_last_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one item, idling first at random; returns at the edge that takes it
  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] sample, input logic eos);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= sample;
    end_of_signal_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sample(sample, eos);
    items_sent++;
  endtask

  // stop sending, wait for every owed result and for the block to go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // window size write, only once the block is idle
  task automatic write_window(input logic [CFG_BITS-1:0] size);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    window_cfg = size;
  endtask

  // extremes, ties from a narrow range, otherwise any value
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly small windows, now and then the full row, zero or a saturating size
  function automatic logic [CFG_BITS-1:0] pick_window();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_BITS'(MAX_WINDOW);
      2:       return CFG_BITS'($urandom_range(31, MAX_WINDOW + 1));
      3:       return CFG_BITS'($urandom_range(MAX_WINDOW - 1, 7));
      default: return CFG_BITS'($urandom_range(6, 1));
    endcase
  endfunction

  // reset size of three, sample extremes, ends with a full tail
  task automatic test_reset_size();
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(16'sd32767, 1'b1);
  endtask

  // signal ends before a window fills, and a signal of one item
  task automatic test_short_signals();
    write_window(5);
    send_item(16'sd100, 1'b0);
    send_item(-16'sd100, 1'b1);
    send_item(-16'sd7, 1'b1);
  endtask

  // even window, floored mean at both ends of the range
  task automatic test_even_mean();
    write_window(2);
    send_item(-16'sd32768, 1'b0);
    send_item(-16'sd32767, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd32766, 1'b0);
    send_item(16'sd1, 1'b1);
  endtask

  // size zero acts as one, the top code saturates to the row length
  task automatic test_size_clamp();
    write_window(0);
    send_item(16'sd5, 1'b0);
    send_item(-16'sd5, 1'b1);
    write_window(31);
    send_item(16'sd11, 1'b0);
    send_item(-16'sd12, 1'b0);
    send_item(16'sd13, 1'b1);
  endtask

  // new size takes effect over the samples already held
  task automatic test_resize_mid_signal();
    write_window(4);
    send_item(16'sd10, 1'b0);
    send_item(16'sd20, 1'b0);
    send_item(16'sd30, 1'b0);
    write_window(1);
    send_item(16'sd40, 1'b0);
    write_window(3);
    send_item(16'sd50, 1'b1);
  endtask

  // random signals in three idling phases, sizes changed between and within signals
  task automatic test_random_streams();
    int unsigned phase;
    int unsigned target;
    int unsigned len;
    int unsigned split;
    int unsigned n;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct   = 14;
          out_stall_pct = 74;
        end
        1: begin
          in_idle_pct   = 74;
          out_stall_pct = 14;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      target = items_sent + 75;
      while (items_sent < target) begin
        if ($urandom_range(2) == 0) write_window(pick_window());
        // lengths up to six items past the window, now and then a short one of one to three items
        if ($urandom_range(4) == 0) len = $urandom_range(3, 1);
        else len = $urandom_range(active_window() + 6, 1);
        split = ($urandom_range(9) == 0) ? $urandom_range(len, 1) : 0;
        for (n = 1; n <= len; n++) begin
          send_item(random_sample(), n == len);
          if (n == split && n < len) write_window(pick_window());
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size();
    test_short_signals();
    test_even_mean();
    test_size_clamp();
    test_resize_mid_signal();
    test_random_streams();

    // drain and let the block go quiet before the verdict
    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sliding_median_filter.f
+incdir+hw/rtl
hw/rtl/smf_pkg.sv
hw/rtl/smf_cell.sv
hw/rtl/sliding_median_filter.sv
dv/sliding_median_filter_test.sv
